FILE: rtl/clk24h_pkg.sv
// Package with the request codes, field widths, reset values and digit helpers of the 24 h clock.
`default_nettype none

package clk24h_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] REQ_SECOND = 2'd0;
	localparam logic [1:0] REQ_SCAN   = 2'd1;
	localparam logic [1:0] REQ_BUTTON = 2'd2;

	// Button bit positions.
	localparam int BTN_MIN_DOWN  = 0;
	localparam int BTN_MIN_UP    = 1;
	localparam int BTN_HOUR_DOWN = 2;
	localparam int BTN_HOUR_UP   = 3;
	localparam int BTN_COUNT     = 4;

	// Field widths.
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int DIGIT_W = 4;
	localparam int PHASE_W = 3;
	localparam int PORT_W  = 8;
	localparam int OUT_W   = 32;

	// Time limits and reset values.
	localparam logic [SEC_W-1:0]  SEC_WRAP   = 6'd60;
	localparam logic [MIN_W-1:0]  MIN_WRAP   = 6'd60;
	localparam logic [MIN_W-1:0]  MIN_MAX    = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_WRAP  = 5'd24;
	localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
	localparam logic [SEC_W-1:0]  SEC_RESET  = 6'd40;
	localparam logic [MIN_W-1:0]  MIN_RESET  = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd23;

	// Display multiplexer.
	localparam logic [PHASE_W-1:0] PHASE_COLON = 3'd4;
	localparam logic [PORT_W-1:0]  PORT_COLON  = 8'b1100_0000;

	typedef struct packed {
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] ones;
	} bcd_pair_t;

	// Splits a value below 60 into decimal tens and ones with a compare chain.
	function automatic bcd_pair_t split_decimal(input logic [MIN_W-1:0] value);
		bcd_pair_t          res;
		logic [MIN_W-1:0]   rest;
		if (value >= 6'd50) begin
			res.tens = 4'd5;
			rest     = value - 6'd50;
		end else if (value >= 6'd40) begin
			res.tens = 4'd4;
			rest     = value - 6'd40;
		end else if (value >= 6'd30) begin
			res.tens = 4'd3;
			rest     = value - 6'd30;
		end else if (value >= 6'd20) begin
			res.tens = 4'd2;
			rest     = value - 6'd20;
		end else if (value >= 6'd10) begin
			res.tens = 4'd1;
			rest     = value - 6'd10;
		end else begin
			res.tens = 4'd0;
			rest     = value;
		end
		res.ones = rest[DIGIT_W-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/clock_24h_with_set_buttons_top.sv
// Top level of the 24 h clock with set buttons and a multiplexed display driver.
//
// Channel   Direction  Handshake                   Contents
// s_axis    in         s_axis_tvalid/tready        tuser: req_type; tdata: buttons
// m_axis    out        m_axis_tvalid/tready        tdata: hours, minutes, seconds,
//                                                  colon_on, segment_port
//
// Every transaction passes through the input register and then the result register;
// the state update sits between the two registers. One transaction can be accepted
// every cycle while the result register is not stalled.
// arst_n clears the time to 23:59:40, the colon, digits, scan phase and button history.
// A stalled result register holds the input register, and a full input register
// that cannot move on holds s_axis_tready low.
`default_nettype none

module clock_24h_with_set_buttons_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [3:0] buttons, [7:4] zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // [4:0] hours, [10:5] minutes, [16:11] seconds,
	                                        // [17] colon_on, [25:18] segment_port, [31:26] zero
);

	localparam int HW = clk24h_pkg::HOUR_W;
	localparam int MW = clk24h_pkg::MIN_W;
	localparam int SW = clk24h_pkg::SEC_W;
	localparam int DW = clk24h_pkg::DIGIT_W;
	localparam int PW = clk24h_pkg::PHASE_W;
	localparam int BN = clk24h_pkg::BTN_COUNT;
	localparam int OW = clk24h_pkg::PORT_W;

	// Input register.
	logic          valid_s1;
	logic [1:0]    req_s1;
	logic [BN-1:0] buttons_s1;

	// Result register.
	logic                                 valid_s2;
	logic [clk24h_pkg::OUT_W-1:0]         data_s2;

	// Clock state.
	logic [SW-1:0] sec_q;
	logic [MW-1:0] min_q;
	logic [HW-1:0] hour_q;
	logic          colon_q;
	logic [DW-1:0] digit_q [4];
	logic [PW-1:0] phase_q;
	logic [BN-1:0] prev_btn_q;
	logic [BN-1:0] pressed_q;

	// Next state.
	logic [SW-1:0] sec_d;
	logic [MW-1:0] min_d;
	logic [HW-1:0] hour_d;
	logic          colon_d;
	logic          refresh_d;
	logic [PW-1:0] phase_d;
	logic [BN-1:0] prev_btn_d;
	logic [BN-1:0] pressed_d;
	logic [OW-1:0] port_d;

	clk24h_pkg::bcd_pair_t min_bcd;
	clk24h_pkg::bcd_pair_t hour_bcd;

	logic advance;

	// The input stage moves on when the result register is empty or being drained.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	// Input register capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1     <= s_axis_tuser;
			buttons_s1 <= s_axis_tdata[BN-1:0];
		end
	end

	// State update for the transaction held in the input register.
	always_comb begin
		sec_d      = sec_q;
		min_d      = min_q;
		hour_d     = hour_q;
		colon_d    = colon_q;
		refresh_d  = 1'b0;
		phase_d    = phase_q;
		prev_btn_d = prev_btn_q;
		pressed_d  = pressed_q;
		port_d     = '0;
		unique case (req_s1)
			clk24h_pkg::REQ_SECOND: begin
				sec_d = sec_q + 1'b1;
				if (sec_d >= clk24h_pkg::SEC_WRAP) begin
					sec_d = '0;
					min_d = min_q + 1'b1;
					if (min_d >= clk24h_pkg::MIN_WRAP) begin
						min_d  = '0;
						hour_d = hour_q + 1'b1;
						if (hour_d >= clk24h_pkg::HOUR_WRAP) begin
							hour_d = '0;
						end
					end
				end
				colon_d   = !colon_q;
				refresh_d = 1'b1;
			end
			clk24h_pkg::REQ_SCAN: begin
				if (phase_q < clk24h_pkg::PHASE_COLON) begin
					port_d = {1'b1, 1'b0, phase_q[1:0], digit_q[phase_q[1:0]]};
				end else begin
					port_d = colon_q ? clk24h_pkg::PORT_COLON : '0;
				end
				phase_d = (phase_q >= clk24h_pkg::PHASE_COLON) ? '0 : phase_q + 1'b1;
			end
			clk24h_pkg::REQ_BUTTON: begin
				// Buttons are handled in bit order; each sees the time left by the one before.
				for (int b = 0; b < BN; b++) begin
					if (!prev_btn_q[b] && buttons_s1[b]) begin
						pressed_d[b] = 1'b1;
					end
					if (pressed_d[b] && !buttons_s1[b]) begin
						pressed_d[b] = 1'b0;
						refresh_d    = 1'b1;
						sec_d        = '0;
						if (b == clk24h_pkg::BTN_MIN_DOWN) begin
							min_d = (min_d == '0) ? clk24h_pkg::MIN_MAX : min_d - 1'b1;
						end else if (b == clk24h_pkg::BTN_MIN_UP) begin
							min_d = (min_d >= clk24h_pkg::MIN_MAX) ? '0 : min_d + 1'b1;
						end else if (b == clk24h_pkg::BTN_HOUR_DOWN) begin
							hour_d = (hour_d == '0) ? clk24h_pkg::HOUR_MAX : hour_d - 1'b1;
						end else begin
							hour_d = (hour_d >= clk24h_pkg::HOUR_MAX) ? '0 : hour_d + 1'b1;
						end
					end
				end
				prev_btn_d = buttons_s1;
			end
			default: begin
			end
		endcase
	end

	// Decimal digits of the new time.
	assign min_bcd  = clk24h_pkg::split_decimal(min_d);
	assign hour_bcd = clk24h_pkg::split_decimal({1'b0, hour_d});

	// Clock state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= clk24h_pkg::SEC_RESET;
			min_q      <= clk24h_pkg::MIN_RESET;
			hour_q     <= clk24h_pkg::HOUR_RESET;
			colon_q    <= 1'b0;
			digit_q[0] <= '0;
			digit_q[1] <= '0;
			digit_q[2] <= '0;
			digit_q[3] <= '0;
			phase_q    <= '0;
			prev_btn_q <= '0;
			pressed_q  <= '0;
		end else if (advance) begin
			sec_q      <= sec_d;
			min_q      <= min_d;
			hour_q     <= hour_d;
			colon_q    <= colon_d;
			phase_q    <= phase_d;
			prev_btn_q <= prev_btn_d;
			pressed_q  <= pressed_d;
			if (refresh_d) begin
				digit_q[0] <= min_bcd.ones;
				digit_q[1] <= min_bcd.tens;
				digit_q[2] <= hour_bcd.ones;
				digit_q[3] <= hour_bcd.tens;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {6'd0, port_d, colon_d, sec_d, min_d, hour_d};
		end
	end

endmodule

`default_nettype wire

FILE: verif/clock_24h_with_set_buttons_top_tb.sv
// Self-checking testbench for the 24 h clock top level with set buttons and display scan.
`timescale 1ns / 100ps

module clock_24h_with_set_buttons_top_tb;

	localparam int          CLK_HALF     = 5;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PRINT_CAP    = 40;
	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	localparam logic [3:0]  BTN_NONE     = 4'b0000;
	localparam logic [3:0]  BTN_ALL      = 4'b1111;

	// One clock readout as it leaves the block.
	typedef struct packed {
		logic [clk24h_pkg::HOUR_W-1:0] hours;
		logic [clk24h_pkg::MIN_W-1:0]  minutes;
		logic [clk24h_pkg::SEC_W-1:0]  seconds;
		logic                          colon;
		logic [clk24h_pkg::PORT_W-1:0] port;
	} readout_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [3:0] buttons, [7:4] zero
	logic [1:0]  s_axis_tuser;   // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [4:0] hours, [10:5] minutes, [16:11] seconds,
	                             // [17] colon_on, [25:18] segment_port

	// Predicted clock state.
	logic [clk24h_pkg::SEC_W-1:0]   clk_sec;
	logic [clk24h_pkg::MIN_W-1:0]   clk_min;
	logic [clk24h_pkg::HOUR_W-1:0]  clk_hour;
	logic                           colon_q;
	logic [clk24h_pkg::DIGIT_W-1:0] digits_q [4];
	logic [clk24h_pkg::PHASE_W-1:0] scan_q;
	logic [3:0]                     btn_last;
	logic [3:0]                     btn_armed;

	readout_t expected_readouts [$];
	int       mismatch_count;
	int       cycle_count;
	bit       idle_en;

	clock_24h_with_set_buttons_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The display digits follow the time only when refreshed.
	function void refresh_digits();
		digits_q[3] = clk24h_pkg::DIGIT_W'(clk_hour / 10);
		digits_q[2] = clk24h_pkg::DIGIT_W'(clk_hour % 10);
		digits_q[1] = clk24h_pkg::DIGIT_W'(clk_min / 10);
		digits_q[0] = clk24h_pkg::DIGIT_W'(clk_min % 10);
	endfunction

	// One button release moves minutes or hours by one with wrap, and zeroes the seconds.
	function void adjust_time(input int which);
		case (which)
			clk24h_pkg::BTN_MIN_DOWN:
				clk_min = (clk_min == 0) ? clk24h_pkg::MIN_MAX : clk_min - 1'b1;
			clk24h_pkg::BTN_MIN_UP:
				clk_min = (clk_min >= clk24h_pkg::MIN_MAX) ? '0 : clk_min + 1'b1;
			clk24h_pkg::BTN_HOUR_DOWN:
				clk_hour = (clk_hour == 0) ? clk24h_pkg::HOUR_MAX : clk_hour - 1'b1;
			default:
				clk_hour = (clk_hour >= clk24h_pkg::HOUR_MAX) ? '0 : clk_hour + 1'b1;
		endcase
		refresh_digits();
		clk_sec = '0;
	endfunction

	// Applies one accepted transaction to the predicted state and queues the readout.
	function void predict_clock(input logic [1:0] req, input logic [3:0] btn);
		readout_t r;
		r.port = '0;
		case (req)
			clk24h_pkg::REQ_SECOND: begin
				if (clk_sec >= clk24h_pkg::SEC_WRAP - 1'b1) begin
					clk_sec = '0;
					if (clk_min >= clk24h_pkg::MIN_MAX) begin
						clk_min  = '0;
						clk_hour = (clk_hour >= clk24h_pkg::HOUR_MAX) ? '0 : clk_hour + 1'b1;
					end else begin
						clk_min = clk_min + 1'b1;
					end
				end else begin
					clk_sec = clk_sec + 1'b1;
				end
				refresh_digits();
				colon_q = ~colon_q;
			end
			clk24h_pkg::REQ_SCAN: begin
				if (scan_q < clk24h_pkg::PHASE_COLON)
					r.port = {2'b10, scan_q[1:0], digits_q[scan_q[1:0]]};
				else
					r.port = colon_q ? clk24h_pkg::PORT_COLON : '0;
				scan_q = (scan_q >= clk24h_pkg::PHASE_COLON) ? '0 : scan_q + 1'b1;
			end
			clk24h_pkg::REQ_BUTTON: begin
				for (int b = 0; b < clk24h_pkg::BTN_COUNT; b++) begin
					if (!btn_last[b] && btn[b])
						btn_armed[b] = 1'b1;
					if (btn_armed[b] && !btn[b]) begin
						btn_armed[b] = 1'b0;
						adjust_time(b);
					end
				end
				btn_last = btn;
			end
			default: begin
				// The unused request kind only reports the time.
			end
		endcase
		r.hours   = clk_hour;
		r.minutes = clk_min;
		r.seconds = clk_sec;
		r.colon   = colon_q;
		expected_readouts.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d",
				cycle_count, what, got, want);
	endtask

	// Sends one transaction, starting and ending at a falling edge.
	task automatic send_item(input logic [1:0] req, input logic [3:0] btn);
		int n;
		n = idle_en ? gap_len() : 0;
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {4'b0000, btn};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_clock(req, btn);
		@(negedge clk);
	endtask

	// A random request kind weighted toward real traffic.
	function automatic logic [1:0] pick_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return clk24h_pkg::REQ_SECOND;
		else if (r < 70)
			return clk24h_pkg::REQ_SCAN;
		else if (r < 95)
			return clk24h_pkg::REQ_BUTTON;
		return REQ_UNUSED;
	endfunction

	// Digits read zero after reset, and the colon phase is dark.
	task automatic test_reset_display();
		repeat (clk24h_pkg::PHASE_COLON + 1) send_item(clk24h_pkg::REQ_SCAN, BTN_NONE);
		send_item(REQ_UNUSED, BTN_ALL);
	endtask

	// From 23:59:40 the seconds carry through minutes and hours to midnight.
	task automatic test_midnight_rollover();
		repeat (21) send_item(clk24h_pkg::REQ_SECOND, BTN_NONE);
		repeat (clk24h_pkg::PHASE_COLON + 1) send_item(clk24h_pkg::REQ_SCAN, BTN_NONE);
	endtask

	// Every button, each wrap, and all four released in one sample.
	task automatic test_set_buttons();
		send_item(clk24h_pkg::REQ_BUTTON, BTN_ALL);
		send_item(clk24h_pkg::REQ_BUTTON, BTN_NONE);
		send_item(clk24h_pkg::REQ_BUTTON, 4'(1 << clk24h_pkg::BTN_MIN_DOWN));
		send_item(clk24h_pkg::REQ_BUTTON, BTN_NONE);
		send_item(clk24h_pkg::REQ_BUTTON, 4'(1 << clk24h_pkg::BTN_HOUR_DOWN));
		send_item(clk24h_pkg::REQ_BUTTON, 4'(1 << clk24h_pkg::BTN_HOUR_DOWN));
		send_item(clk24h_pkg::REQ_BUTTON, BTN_NONE);
		send_item(clk24h_pkg::REQ_BUTTON, 4'(1 << clk24h_pkg::BTN_MIN_UP));
		send_item(clk24h_pkg::REQ_BUTTON, 4'(1 << clk24h_pkg::BTN_HOUR_UP));
		send_item(clk24h_pkg::REQ_BUTTON, BTN_NONE);
		repeat (clk24h_pkg::PHASE_COLON + 1) send_item(clk24h_pkg::REQ_SCAN, BTN_NONE);
	endtask

	// Fully random transactions, with stretches where neither side idles.
	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			send_item(pick_req(), 4'($urandom_range(0, 15)));
		end
	endtask

	// Press and release sequences with random buttons, mixed with ticks, scans and noise.
	task automatic test_button_sequences(input int rounds);
		logic [3:0] held;
		int         hold;
		for (int i = 0; i < rounds; i++) begin
			idle_en = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 4) == 0) begin
				send_item(clk24h_pkg::REQ_BUTTON, 4'($urandom_range(0, 15)));
			end else begin
				held = 4'($urandom_range(1, 15));
				hold = $urandom_range(1, 3);
				for (int k = 0; k < hold; k++) begin
					send_item(clk24h_pkg::REQ_BUTTON, held);
					if ($urandom_range(0, 1) == 1)
						send_item(pick_req() == clk24h_pkg::REQ_SECOND ?
							clk24h_pkg::REQ_SECOND : clk24h_pkg::REQ_SCAN, BTN_NONE);
				end
				// Release some or all of the held buttons.
				send_item(clk24h_pkg::REQ_BUTTON, held & 4'($urandom_range(0, 15)));
				send_item(clk24h_pkg::REQ_BUTTON, BTN_NONE);
			end
		end
	endtask

	// Long runs of second ticks with scans reach the minute and hour carries.
	task automatic test_tick_runs(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				idle_en = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 4) == 0)
				send_item(clk24h_pkg::REQ_SCAN, BTN_NONE);
			else
				send_item(clk24h_pkg::REQ_SECOND, BTN_NONE);
		end
	endtask

	// Result checker: each readout against the oldest expectation.
	always @(posedge clk) begin : check_readout
		readout_t got;
		readout_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hours   = m_axis_tdata[4:0];
			got.minutes = m_axis_tdata[10:5];
			got.seconds = m_axis_tdata[16:11];
			got.colon   = m_axis_tdata[17];
			got.port    = m_axis_tdata[25:18];
			if (expected_readouts.size() == 0) begin
				report_mismatch("unexpected readout, hours", got.hours, 0);
			end else begin
				want = expected_readouts.pop_front();
				if (got.hours !== want.hours)
					report_mismatch("hours", got.hours, want.hours);
				if (got.minutes !== want.minutes)
					report_mismatch("minutes", got.minutes, want.minutes);
				if (got.seconds !== want.seconds)
					report_mismatch("seconds", got.seconds, want.seconds);
				if (got.colon !== want.colon)
					report_mismatch("colon_on", got.colon, want.colon);
				if (got.port !== want.port)
					report_mismatch("segment_port", got.port, want.port);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("clock_24h_with_set_buttons_top test failed");
			$finish;
		end
	end

	// Receiver side: random stalls of varying length.
	initial begin : result_stall
		int stall;
		stall         = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 7) == 0)
					stall = gap_len();
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = clk24h_pkg::REQ_SECOND;
		mismatch_count = 0;
		cycle_count    = 0;
		idle_en        = 1'b1;
		clk_sec        = clk24h_pkg::SEC_RESET;
		clk_min        = clk24h_pkg::MIN_RESET;
		clk_hour       = clk24h_pkg::HOUR_RESET;
		colon_q        = 1'b0;
		for (int d = 0; d < 4; d++)
			digits_q[d] = '0;
		scan_q    = '0;
		btn_last  = '0;
		btn_armed = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_display();
		test_midnight_rollover();
		test_set_buttons();
		test_random_mix(450);
		test_button_sequences(80);
		test_tick_runs(250);
		s_axis_tvalid <= 1'b0;

		// Drain outstanding readouts, then let the pipeline settle.
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("clock_24h_with_set_buttons_top test passed");
		else
			$display("clock_24h_with_set_buttons_top test failed");
		$finish;
	end

endmodule
